>>> rtl/lfu_pkg.sv
package lfu_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned CFG_W  = 5;

    // operation codes
    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    localparam logic [DATA_W-1:0] READ_MISS  = 32'hFFFF_FFFF;
    localparam logic [DATA_W-1:0] COUNT_MAX  = 32'hFFFF_FFFF;
    localparam logic [DATA_W-1:0] COUNT_INIT = 32'd1;
    localparam logic [CFG_W-1:0]  CAP_RESET  = 5'd16;

    // contents of one cache cell
    typedef struct packed {
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] count;
    } entry_t;

    // search token that walks down the cell row
    typedef struct packed {
        logic              found;
        logic              have;
        logic [DATA_W-1:0] fnd_value;
        logic [DATA_W-1:0] fnd_count;
        logic [DATA_W-1:0] min_count;
    } tok_t;

endpackage

>>> rtl/lfu_cell.sv
// One cache entry. Cells are kept in recency order: cell 0 is the most
// recent and the valid cells are packed at the low end of the row.
module lfu_cell #(
    parameter int IW         = 4,
    parameter int CELL_INDEX = 0
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // search key, held stable by the controller during a scan
    input  logic [31:0]           key_i,
    // token from the previous cell
    input  logic                  tok_vld_i,
    input  lfu_pkg::tok_t         tok_i,
    input  logic [IW-1:0]         tok_fpos_i,
    input  logic [IW-1:0]         tok_mpos_i,
    // token to the next cell
    output logic                  tok_vld_o,
    output lfu_pkg::tok_t         tok_o,
    output logic [IW-1:0]         tok_fpos_o,
    output logic [IW-1:0]         tok_mpos_o,
    // shift path: contents of the previous cell (new entry for cell 0)
    input  logic                  shift_valid_i,
    input  lfu_pkg::entry_t       shift_entry_i,
    input  logic                  apply_en_i,
    input  logic [IW-1:0]         apply_pos_i,
    // own contents, to the next cell
    output logic                  valid_o,
    output lfu_pkg::entry_t       entry_o
);

    localparam logic [IW-1:0] IDX = IW'(CELL_INDEX);

    logic            valid_reg;
    lfu_pkg::entry_t entry_reg;
    logic            tok_vld_reg;
    lfu_pkg::tok_t   tok_reg;
    logic [IW-1:0]   fpos_reg;
    logic [IW-1:0]   mpos_reg;

    lfu_pkg::tok_t   tok_next;
    logic [IW-1:0]   fpos_next;
    logic [IW-1:0]   mpos_next;

    // key match and running minimum; ties go to the later (less recent) cell
    always_comb begin
        tok_next  = tok_i;
        fpos_next = tok_fpos_i;
        mpos_next = tok_mpos_i;
        if (valid_reg && (entry_reg.key == key_i) && !tok_i.found) begin
            tok_next.found     = 1'b1;
            tok_next.fnd_value = entry_reg.value;
            tok_next.fnd_count = entry_reg.count;
            fpos_next          = IDX;
        end
        if (valid_reg && (!tok_i.have || (entry_reg.count <= tok_i.min_count))) begin
            tok_next.have      = 1'b1;
            tok_next.min_count = entry_reg.count;
            mpos_next          = IDX;
        end
    end

    // token stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_vld_reg <= 1'b0;
        end else begin
            tok_vld_reg <= tok_vld_i;
        end
        tok_reg  <= tok_next;
        fpos_reg <= fpos_next;
        mpos_reg <= mpos_next;
    end

    // entry storage: cells up to the removed position move down by one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (apply_en_i && (IDX <= apply_pos_i)) begin
            valid_reg <= shift_valid_i;
        end
        if (apply_en_i && (IDX <= apply_pos_i)) begin
            entry_reg <= shift_entry_i;
        end
    end

    assign tok_vld_o  = tok_vld_reg;
    assign tok_o      = tok_reg;
    assign tok_fpos_o = fpos_reg;
    assign tok_mpos_o = mpos_reg;
    assign valid_o    = valid_reg;
    assign entry_o    = entry_reg;

endmodule

>>> rtl/lfu_ctrl.sv
// Request sequencer: takes an item, launches the search token, acts on the
// token when it leaves the last cell and holds the result for the output.
module lfu_ctrl #(
    parameter int CAPACITY = 16,
    parameter int IW       = 4,
    parameter int UW       = 5
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_operation,
    input  logic signed [31:0]  s_lookup_key,
    input  logic signed [31:0]  s_store_value,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_hit,
    output logic signed [31:0]  m_read_value,
    output logic                m_evicted,
    input  logic                cfg_wen,
    input  logic [4:0]          cfg_wdata,
    // to the cell row
    output logic [31:0]         search_key,
    output logic                inject,
    input  logic                tail_vld,
    input  lfu_pkg::tok_t       tail_tok,
    input  logic [IW-1:0]       tail_fpos,
    input  logic [IW-1:0]       tail_mpos,
    output logic                apply_en,
    output logic [IW-1:0]       apply_pos,
    output lfu_pkg::entry_t     new_entry
);

    localparam int CW = (UW > lfu_pkg::CFG_W) ? UW : lfu_pkg::CFG_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]               state_reg, state_next;
    logic                     start_reg;
    logic                     op_reg;
    logic [31:0]              key_reg;
    logic [31:0]              val_reg;
    logic [lfu_pkg::CFG_W-1:0] cap_reg;
    logic [UW-1:0]            used_reg;
    logic                     res_hit_reg, res_hit_next;
    logic [31:0]              res_rd_reg, res_rd_next;
    logic                     res_ev_reg, res_ev_next;
    logic                     m_valid_reg;
    logic                     m_hit_reg;
    logic [31:0]              m_rd_reg;
    logic                     m_ev_reg;

    logic [CW-1:0]            used_w;
    logic [CW-1:0]            cfg_w;
    logic [CW-1:0]            eff_cap;
    logic                     free_ok;
    logic                     used_inc;
    logic [31:0]              bumped;
    logic                     out_free;

    assign s_ready    = (state_reg == ST_IDLE);
    assign search_key = key_reg;
    assign inject     = start_reg;
    assign out_free   = !m_valid_reg || m_ready;

    // effective capacity and free slot check
    assign used_w  = CW'(used_reg);
    assign cfg_w   = CW'(cap_reg);
    assign eff_cap = (cfg_w < CW'(CAPACITY)) ? cfg_w : CW'(CAPACITY);
    assign free_ok = used_w < eff_cap;

    assign bumped = (tail_tok.fnd_count == lfu_pkg::COUNT_MAX) ?
                    tail_tok.fnd_count : tail_tok.fnd_count + 32'd1;

    // decision when the token leaves the last cell
    always_comb begin
        apply_en     = 1'b0;
        apply_pos    = tail_fpos;
        new_entry    = '{key: key_reg, value: tail_tok.fnd_value, count: bumped};
        used_inc     = 1'b0;
        res_hit_next = 1'b0;
        res_rd_next  = lfu_pkg::READ_MISS;
        res_ev_next  = 1'b0;
        if (op_reg == lfu_pkg::OP_GET) begin
            if (tail_tok.found) begin
                res_hit_next = 1'b1;
                res_rd_next  = tail_tok.fnd_value;
                apply_en     = tail_vld;
            end
        end else if (cap_reg != '0) begin
            if (tail_tok.found) begin
                res_hit_next    = 1'b1;
                apply_en        = tail_vld;
                new_entry.value = val_reg;
            end else begin
                apply_en  = tail_vld;
                new_entry = '{key: key_reg, value: val_reg, count: lfu_pkg::COUNT_INIT};
                if (free_ok) begin
                    apply_pos = used_reg[IW-1:0];
                    used_inc  = tail_vld;
                end else begin
                    apply_pos   = tail_mpos;
                    res_ev_next = 1'b1;
                end
            end
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (tail_vld) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            start_reg   <= 1'b0;
            cap_reg     <= lfu_pkg::CAP_RESET;
            used_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            start_reg <= s_valid && s_ready;
            if (cfg_wen) begin
                cap_reg <= cfg_wdata;
            end
            if (used_inc) begin
                used_reg <= used_reg + UW'(1);
            end
            if ((state_reg == ST_DONE) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // item and result payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg  <= s_operation;
            key_reg <= s_lookup_key;
            val_reg <= s_store_value;
        end
        if ((state_reg == ST_SCAN) && tail_vld) begin
            res_hit_reg <= res_hit_next;
            res_rd_reg  <= res_rd_next;
            res_ev_reg  <= res_ev_next;
        end
        if ((state_reg == ST_DONE) && out_free) begin
            m_hit_reg <= res_hit_reg;
            m_rd_reg  <= res_rd_reg;
            m_ev_reg  <= res_ev_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_hit        = m_hit_reg;
    assign m_read_value = m_rd_reg;
    assign m_evicted    = m_ev_reg;

endmodule

>>> rtl/lfu_cache_table.sv
// LFU cache: a row of CAPACITY cells in recency order, searched by a token
// that moves one cell per cycle and carries the key match and the victim.
// Only one item is in the block at a time: a new item is taken once the
// result of the last one has moved to the output register.
// Reset (aresetn, synchronous, active low) clears all cell valid bits, the
// entry count and the handshake, and sets the capacity register to 16.
module lfu_cache_table #(
    parameter int CAPACITY = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_operation,
    input  logic signed [31:0]  s_lookup_key,
    input  logic signed [31:0]  s_store_value,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_hit,
    output logic signed [31:0]  m_read_value,
    output logic                m_evicted,
    input  logic                cfg_wen,
    input  logic [4:0]          cfg_wdata
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int UW = $clog2(CAPACITY + 1);

    logic [31:0]      search_key;
    logic             inject;
    logic             apply_en;
    logic [IW-1:0]    apply_pos;
    lfu_pkg::entry_t  new_entry;

    logic             tok_vld  [CAPACITY+1];
    lfu_pkg::tok_t    tok      [CAPACITY+1];
    logic [IW-1:0]    tok_fpos [CAPACITY+1];
    logic [IW-1:0]    tok_mpos [CAPACITY+1];
    logic             cell_valid [CAPACITY];
    lfu_pkg::entry_t  cell_entry [CAPACITY];

    // fresh token at the head of the row
    assign tok_vld[0]  = inject;
    assign tok[0]      = '0;
    assign tok_fpos[0] = '0;
    assign tok_mpos[0] = '0;

    lfu_ctrl #(
        .CAPACITY (CAPACITY),
        .IW       (IW),
        .UW       (UW)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_lookup_key  (s_lookup_key),
        .s_store_value (s_store_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hit         (m_hit),
        .m_read_value  (m_read_value),
        .m_evicted     (m_evicted),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .search_key    (search_key),
        .inject        (inject),
        .tail_vld      (tok_vld[CAPACITY]),
        .tail_tok      (tok[CAPACITY]),
        .tail_fpos     (tok_fpos[CAPACITY]),
        .tail_mpos     (tok_mpos[CAPACITY]),
        .apply_en      (apply_en),
        .apply_pos     (apply_pos),
        .new_entry     (new_entry)
    );

    // cell row; cell 0 takes the new or touched entry
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic            sh_valid;
        lfu_pkg::entry_t sh_entry;

        if (i == 0) begin : g_head
            assign sh_valid = 1'b1;
            assign sh_entry = new_entry;
        end else begin : g_body
            assign sh_valid = cell_valid[i-1];
            assign sh_entry = cell_entry[i-1];
        end

        lfu_cell #(
            .IW         (IW),
            .CELL_INDEX (i)
        ) u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .key_i         (search_key),
            .tok_vld_i     (tok_vld[i]),
            .tok_i         (tok[i]),
            .tok_fpos_i    (tok_fpos[i]),
            .tok_mpos_i    (tok_mpos[i]),
            .tok_vld_o     (tok_vld[i+1]),
            .tok_o         (tok[i+1]),
            .tok_fpos_o    (tok_fpos[i+1]),
            .tok_mpos_o    (tok_mpos[i+1]),
            .shift_valid_i (sh_valid),
            .shift_entry_i (sh_entry),
            .apply_en_i    (apply_en),
            .apply_pos_i   (apply_pos),
            .valid_o       (cell_valid[i]),
            .entry_o       (cell_entry[i])
        );
    end

endmodule

>>> verif/lfu_result_checker.sv
module lfu_result_checker #(
    parameter int CAPACITY = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  logic                      s_operation,
    input  logic signed [31:0]        s_lookup_key,
    input  logic signed [31:0]        s_store_value,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  logic                      m_hit,
    input  logic signed [31:0]        m_read_value,
    input  logic                      m_evicted,
    input  logic                      cfg_wen,
    input  logic [lfu_pkg::CFG_W-1:0] cfg_wdata,
    output int                        mismatches,
    output int                        outstanding
);

    typedef struct packed {
        logic                       hit;
        logic [lfu_pkg::DATA_W-1:0] read_value;
        logic                       evicted;
    } lookup_result_t;

    // shadow copy of the cache contents
    logic                       slot_valid [CAPACITY];
    logic [lfu_pkg::DATA_W-1:0] slot_key   [CAPACITY];
    logic [lfu_pkg::DATA_W-1:0] slot_value [CAPACITY];
    logic [lfu_pkg::DATA_W-1:0] slot_count [CAPACITY];
    logic [4:0]                 slot_rank  [CAPACITY];   // 0 = most recent
    int unsigned                fill_level;
    logic [lfu_pkg::CFG_W-1:0]  capacity_reg;

    lookup_result_t    result_q[$];
    int                fail_total = 0;
    int                result_num = 0;

    // bump use count (saturating) and move the slot to the front
    task automatic touch_slot(input int s);
        logic [4:0] old_rank;
        int i;
        if (slot_count[s] != lfu_pkg::COUNT_MAX)
            slot_count[s] = slot_count[s] + 1;
        old_rank = slot_rank[s];
        for (i = 0; i < CAPACITY; i++)
            if (slot_valid[i] && i != s && slot_rank[i] < old_rank)
                slot_rank[i] = slot_rank[i] + 1;
        slot_rank[s] = '0;
    endtask

    // apply one get/put to the shadow table and return its answer
    task automatic predict_lookup(input logic op, input logic [lfu_pkg::DATA_W-1:0] key,
                                  input logic [lfu_pkg::DATA_W-1:0] val,
                                  output lookup_result_t res);
        int unsigned eff_cap;
        int slot;
        int i;
        bit found;
        bit have;
        logic [4:0] old_rank;
        eff_cap = (capacity_reg < CAPACITY) ? capacity_reg : CAPACITY;
        res.hit = 1'b0;
        res.read_value = lfu_pkg::READ_MISS;
        res.evicted = 1'b0;
        found = 0;
        have = 0;
        slot = 0;
        for (i = 0; i < CAPACITY; i++)
            if (!found && slot_valid[i] && slot_key[i] == key) begin
                slot = i;
                found = 1;
            end

        if (op == lfu_pkg::OP_GET) begin
            if (found) begin
                res.hit = 1'b1;
                res.read_value = slot_value[slot];
                touch_slot(slot);
            end
        end else if (eff_cap != 0) begin
            if (found) begin
                res.hit = 1'b1;
                slot_value[slot] = val;
                touch_slot(slot);
            end else begin
                // free slot while below the capacity
                if (fill_level < eff_cap) begin
                    for (i = 0; i < CAPACITY; i++)
                        if (!have && !slot_valid[i]) begin
                            slot = i;
                            have = 1;
                        end
                    if (have)
                        fill_level++;
                end
                // victim: lowest count, least recent among ties
                if (!have) begin
                    for (i = 0; i < CAPACITY; i++) begin
                        if (slot_valid[i] && (!have || slot_count[i] < slot_count[slot] ||
                            (slot_count[i] == slot_count[slot] &&
                             slot_rank[i] > slot_rank[slot]))) begin
                            slot = i;
                            have = 1;
                        end
                    end
                    if (have) begin
                        old_rank = slot_rank[slot];
                        res.evicted = 1'b1;
                        slot_valid[slot] = 1'b0;
                        for (i = 0; i < CAPACITY; i++)
                            if (slot_valid[i] && slot_rank[i] > old_rank)
                                slot_rank[i] = slot_rank[i] - 1;
                    end
                end
                if (have) begin
                    for (i = 0; i < CAPACITY; i++)
                        if (slot_valid[i])
                            slot_rank[i] = slot_rank[i] + 1;
                    slot_valid[slot] = 1'b1;
                    slot_key[slot]   = key;
                    slot_value[slot] = val;
                    slot_count[slot] = lfu_pkg::COUNT_INIT;
                    slot_rank[slot]  = '0;
                end
            end
        end
    endtask

    task automatic note_failure(input string msg);
        fail_total++;
        if (fail_total <= 10)
            $display("[%0t] result %0d: %s", $realtime, result_num, msg);
    endtask

    // watch both channels and the register port
    always @(posedge aclk) begin
        lookup_result_t want;
        if (!aresetn) begin
            for (int i = 0; i < CAPACITY; i++)
                slot_valid[i] = 1'b0;
            fill_level = 0;
            capacity_reg = lfu_pkg::CAP_RESET;
            result_q.delete();
        end else begin
            if (s_valid && s_ready) begin
                predict_lookup(s_operation, s_lookup_key, s_store_value, want);
                result_q.push_back(want);
            end
            if (m_valid && m_ready) begin
                if (result_q.size() == 0) begin
                    note_failure($sformatf("unexpected item hit=%0b value=%h evicted=%0b",
                                           m_hit, m_read_value, m_evicted));
                end else begin
                    want = result_q.pop_front();
                    if (m_hit !== want.hit || m_read_value !== want.read_value ||
                        m_evicted !== want.evicted)
                        note_failure($sformatf(
                            "want hit=%0b value=%h evicted=%0b, got hit=%0b value=%h evicted=%0b",
                            want.hit, want.read_value, want.evicted,
                            m_hit, m_read_value, m_evicted));
                end
                result_num++;
            end
            if (cfg_wen)
                capacity_reg = cfg_wdata;
        end
        outstanding <= result_q.size();
        mismatches  <= fail_total;
    end

endmodule

>>> verif/tb_top.sv
module tb_top;

    localparam int CAPACITY    = 16;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 200;
    localparam int NUM_PHASES  = 10;

    logic                      aclk;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    logic                      s_operation;
    logic signed [31:0]        s_lookup_key;
    logic signed [31:0]        s_store_value;
    logic                      m_valid;
    logic                      m_ready;
    logic                      m_hit;
    logic signed [31:0]        m_read_value;
    logic                      m_evicted;
    logic                      cfg_wen;
    logic [lfu_pkg::CFG_W-1:0] cfg_wdata;

    int                 mismatches;
    int                 outstanding;

    bit                 idle_on = 1'b1;
    bit                 hold_off_req = 1'b0;
    bit                 hold_done = 1'b0;
    logic [lfu_pkg::DATA_W-1:0] key_pool[$];

    // capacity per random phase: above the parameter, zero, tiny and full sizes
    int unsigned        phase_cap [NUM_PHASES] = '{31, 3, 0, 1, 2, 8, 5, 16, 12, 16};

    lfu_cache_table #(
        .CAPACITY(CAPACITY)
    ) u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_lookup_key (s_lookup_key),
        .s_store_value(s_store_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hit        (m_hit),
        .m_read_value (m_read_value),
        .m_evicted    (m_evicted),
        .cfg_wen      (cfg_wen),
        .cfg_wdata    (cfg_wdata)
    );

    lfu_result_checker #(
        .CAPACITY(CAPACITY)
    ) u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_lookup_key (s_lookup_key),
        .s_store_value(s_store_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hit        (m_hit),
        .m_read_value (m_read_value),
        .m_evicted    (m_evicted),
        .cfg_wen      (cfg_wen),
        .cfg_wdata    (cfg_wdata),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    // clock
    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // run limit
    initial begin
        #5_000_000;
        $display("lfu_cache_table: mismatch");
        $finish;
    end

    // result side: random back-pressure, or one long hold-off on request
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_req && !hold_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end else begin
                m_ready <= !idle_on || ($urandom_range(0, 99) >= 24);
            end
        end
    end

    // offer one item and wait until it is taken; valid stays up between items unless idling is on
    task automatic send_item(input logic op, input logic [lfu_pkg::DATA_W-1:0] key,
                             input logic [lfu_pkg::DATA_W-1:0] val);
        if (idle_on && $urandom_range(0, 99) < 24) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(0, 99) < 24)
                @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_operation   <= op;
        s_lookup_key  <= key;
        s_store_value <= val;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    // drop valid and wait until every result is back
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
    endtask

    // only called with the block drained
    task automatic set_capacity(input int unsigned cap);
        cfg_wen   <= 1'b1;
        cfg_wdata <= cap[lfu_pkg::CFG_W-1:0];
        @(posedge aclk);
        cfg_wen   <= 1'b0;
    endtask

    // keys for a phase: a few more than the capacity so that puts evict
    task automatic build_pool(input int n);
        int sel;
        key_pool.delete();
        repeat (n) begin
            sel = $urandom_range(0, 3);
            if (sel == 0)
                key_pool.push_back($urandom());
            else if (sel == 1)
                key_pool.push_back(-$urandom_range(1, 40));
            else
                key_pool.push_back($urandom_range(0, 40));
        end
    endtask

    task automatic run_phase(input int unsigned cap, input bit idle, input bit hold);
        int k;
        logic [lfu_pkg::DATA_W-1:0] key;
        set_capacity(cap);
        idle_on = idle;
        build_pool((cap > CAPACITY ? CAPACITY : cap) + $urandom_range(2, 8));
        for (k = 0; k < PHASE_ITEMS; k++) begin
            if (hold && k == PHASE_ITEMS / 4)
                hold_off_req = 1'b1;
            if ($urandom_range(0, 9) == 0)
                key = $urandom();
            else
                key = key_pool[$urandom_range(0, key_pool.size() - 1)];
            send_item($urandom_range(0, 1) ? lfu_pkg::OP_PUT : lfu_pkg::OP_GET, key,
                      $urandom());
        end
        drain_results();
    endtask

    // stimulus and verdict
    initial begin
        int k;
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_operation   <= lfu_pkg::OP_GET;
        s_lookup_key  <= '0;
        s_store_value <= '0;
        cfg_wen       <= 1'b0;
        cfg_wdata     <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty table, key and value extremes, put update
        send_item(lfu_pkg::OP_GET, 32'h0000_0000, 32'h0);
        send_item(lfu_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(lfu_pkg::OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(lfu_pkg::OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
        send_item(lfu_pkg::OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
        send_item(lfu_pkg::OP_GET, 32'h7FFF_FFFF, 32'h0);
        send_item(lfu_pkg::OP_PUT, 32'h8000_0000, 32'h1234_5678);
        send_item(lfu_pkg::OP_GET, 32'h8000_0000, 32'h0);
        // fill to sixteen, then force an eviction with a tie on count
        for (k = 1; k <= 12; k++)
            send_item(lfu_pkg::OP_PUT, k, k * 3);
        send_item(lfu_pkg::OP_PUT, 32'd100, 32'hA5A5_A5A5);
        send_item(lfu_pkg::OP_GET, 32'd100, 32'h0);
        drain_results();

        // zero capacity: a put of a stored key does nothing, gets still work
        set_capacity(0);
        send_item(lfu_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h5555_5555);
        send_item(lfu_pkg::OP_GET, 32'h7FFF_FFFF, 32'h0);
        drain_results();

        // capacity below the entries held: every put miss evicts
        set_capacity(4);
        send_item(lfu_pkg::OP_PUT, 32'd200, 32'd1);
        send_item(lfu_pkg::OP_PUT, 32'd201, 32'd2);
        drain_results();

        // random phases; one without idling, one with a long result hold-off
        for (k = 0; k < NUM_PHASES; k++)
            run_phase(phase_cap[k], k != 7, k == 1);

        repeat (CAPACITY + 2) @(posedge aclk);
        if (mismatches == 0)
            $display("lfu_cache_table: match");
        else
            $display("lfu_cache_table: mismatch");
        $finish;
    end

endmodule

>>> lfu_cache_table.f
rtl/lfu_pkg.sv
rtl/lfu_cell.sv
rtl/lfu_ctrl.sv
rtl/lfu_cache_table.sv
verif/lfu_result_checker.sv
verif/tb_top.sv
